FILE: hw/rtl/cvfc_pkg.sv
// shared types, constants and the crc-15 byte update for the cell voltage frame checker
// used by cvfc_front, cvfc_queue, cvfc_back and cell_voltage_frame_checker_unit
package cvfc_pkg;

  localparam int CHIP_COUNT     = 8;
  localparam int CELLS_PER_CHIP = 12;

  localparam logic [15:0] CRC_POLY  = 16'h4599;
  localparam logic [15:0] CRC_SEED  = 16'd16;
  localparam logic [22:0] TOTAL_MAX = 23'h7fffff;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // frame byte positions
  localparam logic [2:0] POS_FIRST    = 3'd0;
  localparam logic [2:0] POS_PEC_HIGH = 3'd6;
  localparam logic [2:0] POS_PEC_LOW  = 3'd7;

  // reset values of the configuration registers
  localparam logic [15:0] UNDER_RST = 16'd30000;
  localparam logic [15:0] OVER_RST  = 16'd42000;
  localparam logic [22:0] PACK_RST  = 23'd2646000;
  localparam logic [3:0]  EVEN_RST  = 4'd12;
  localparam logic [3:0]  ODD_RST   = 4'd9;

  typedef enum logic [2:0] {
    CFG_UNDER_LIMIT = 3'd0,
    CFG_OVER_LIMIT  = 3'd1,
    CFG_PACK_LIMIT  = 3'd2,
    CFG_EVEN_CELLS  = 3'd3,
    CFG_ODD_CELLS   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] under_limit;
    logic [15:0] over_limit;
    logic [22:0] pack_limit;
    logic [3:0]  even_cells;
    logic [3:0]  odd_cells;
  } cfg_t;

  // one record handed from the front to the back
  typedef struct packed {
    logic             is_frame;
    logic             clear;
    logic             pec_ok;
    logic [2:0]       chip;
    logic [1:0]       group;
    logic [2:0][15:0] cells;
  } rec_t;

  function automatic logic [15:0] crc15_byte(input logic [15:0] rem, input logic [7:0] data);
    logic [15:0] r;
    logic [7:0]  addr;
    addr = rem[14:7] ^ data;
    r    = {1'b0, addr, 7'b0};
    for (int b = 0; b < 8; b++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return {rem[7:0], 8'h00} ^ r;
  endfunction

endpackage

FILE: hw/rtl/cvfc_front.sv
// front end: takes byte beats, runs the crc-15, stores frame bytes and builds records
// depends on cvfc_pkg
module cvfc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  input  logic [2:0]        byte_position,
  input  logic [2:0]        chip_index,
  input  logic [1:0]        group_index,
  input  logic              scan_start,
  input  logic              q_full,
  output logic              push,
  output cvfc_pkg::rec_t    rec
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  fb_r [7];
  logic        fire;
  logic [15:0] pec;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  always_comb begin
    crc_nxt = crc_r;
    if (fire && (byte_position < cvfc_pkg::POS_PEC_HIGH)) begin
      crc_nxt = cvfc_pkg::crc15_byte(
        (byte_position == cvfc_pkg::POS_FIRST) ? cvfc_pkg::CRC_SEED : crc_r, rx_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= cvfc_pkg::CRC_SEED;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (byte_position != cvfc_pkg::POS_PEC_LOW)) begin
      fb_r[byte_position] <= rx_byte;
    end
  end

  assign pec = {crc_r[14:0], 1'b0};

  // clear-only beats still go through the queue to keep ordering with frames
  assign push = fire && ((byte_position == cvfc_pkg::POS_PEC_LOW) || scan_start);

  always_comb begin
    rec.is_frame = (byte_position == cvfc_pkg::POS_PEC_LOW);
    rec.clear    = scan_start;
    rec.pec_ok   = (pec[15:8] == fb_r[6]) && (pec[7:0] == rx_byte);
    rec.chip     = chip_index;
    rec.group    = group_index;
    rec.cells[0] = {fb_r[1], fb_r[0]};
    rec.cells[1] = {fb_r[3], fb_r[2]};
    rec.cells[2] = {fb_r[5], fb_r[4]};
  end

endmodule

FILE: hw/rtl/cvfc_queue.sv
// short record queue between the front and the back
// depends on cvfc_pkg
module cvfc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cvfc_pkg::rec_t  push_rec,
  input  logic            pop,
  output cvfc_pkg::rec_t  head,
  output logic            q_valid,
  output logic            q_full
);

  cvfc_pkg::rec_t              mem_r [cvfc_pkg::QUEUE_DEPTH];
  logic [cvfc_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [cvfc_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [cvfc_pkg::QCNT_W-1:0] count_r, count_nxt;

  localparam logic [cvfc_pkg::QPTR_W-1:0] PTR_LAST = cvfc_pkg::QPTR_W'(cvfc_pkg::QUEUE_DEPTH - 1);
  localparam logic [cvfc_pkg::QCNT_W-1:0] CNT_FULL = cvfc_pkg::QCNT_W'(cvfc_pkg::QUEUE_DEPTH);

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CNT_FULL);
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("queue count past depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !pop |-> !push) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("pop from empty queue");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1) else $error("queue count did not step");

endmodule

FILE: hw/rtl/cvfc_back.sv
// back end: folds records into total, min and max and drives the result register
// depends on cvfc_pkg
module cvfc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  cvfc_pkg::cfg_t  cfg,
  input  cvfc_pkg::rec_t  head,
  input  logic            q_valid,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [71:0]     out_tdata,
  output logic            out_tuser
);

  logic [22:0] total_r, total_nxt;
  logic [15:0] lo_v_r, lo_v_nxt, hi_v_r, hi_v_nxt;
  logic [6:0]  lo_loc_r, lo_loc_nxt, hi_loc_r, hi_loc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [71:0] out_data_r;
  logic        out_user_r;
  logic        slot_free;
  logic        load_out;
  logic [3:0]  sel_cells;
  logic [3:0]  ncells;
  logic [3:0]  cell_idx;
  logic [24:0] sum;
  logic        under_f, over_f, pack_f;

  assign slot_free = !out_valid_r || out_tready;
  assign pop       = q_valid && (!head.is_frame || slot_free);
  assign load_out  = pop && head.is_frame;

  always_comb begin
    sel_cells = head.chip[0] ? cfg.odd_cells : cfg.even_cells;
    ncells    = (int'(sel_cells) > cvfc_pkg::CELLS_PER_CHIP) ?
                4'(cvfc_pkg::CELLS_PER_CHIP) : sel_cells;
    if (int'(head.chip) >= cvfc_pkg::CHIP_COUNT) begin
      ncells = '0;
    end
  end

  always_comb begin
    if (head.clear) begin
      total_nxt  = '0;
      lo_v_nxt   = 16'hffff;
      lo_loc_nxt = '0;
      hi_v_nxt   = '0;
      hi_loc_nxt = '0;
    end else begin
      total_nxt  = total_r;
      lo_v_nxt   = lo_v_r;
      lo_loc_nxt = lo_loc_r;
      hi_v_nxt   = hi_v_r;
      hi_loc_nxt = hi_loc_r;
    end
    sum      = {2'b00, total_nxt};
    cell_idx = '0;
    if (head.is_frame) begin
      // strict compares so a tie keeps the earlier cell
      for (int k = 0; k < 3; k++) begin
        cell_idx = 4'(int'(head.group) * 3 + k);
        if (cell_idx < ncells) begin
          sum = sum + {9'd0, head.cells[k]};
          if (head.cells[k] < lo_v_nxt) begin
            lo_v_nxt   = head.cells[k];
            lo_loc_nxt = {head.chip, cell_idx};
          end
          if (head.cells[k] > hi_v_nxt) begin
            hi_v_nxt   = head.cells[k];
            hi_loc_nxt = {head.chip, cell_idx};
          end
        end
      end
      // saturating per cell is the same as clamping the sum once
      total_nxt = (sum > {2'b00, cvfc_pkg::TOTAL_MAX}) ? cvfc_pkg::TOTAL_MAX : sum[22:0];
    end
    under_f = (lo_v_nxt < cfg.under_limit);
    over_f  = (hi_v_nxt > cfg.over_limit);
    pack_f  = (total_nxt > cfg.pack_limit);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      lo_v_r      <= 16'hffff;
      lo_loc_r    <= '0;
      hi_v_r      <= '0;
      hi_loc_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        total_r  <= total_nxt;
        lo_v_r   <= lo_v_nxt;
        lo_loc_r <= lo_loc_nxt;
        hi_v_r   <= hi_v_nxt;
        hi_loc_r <= hi_loc_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_user_r <= head.pec_ok;
      out_data_r <= {pack_f, over_f, under_f, total_nxt,
                     hi_loc_nxt[3:0], hi_loc_nxt[6:4], hi_v_nxt,
                     lo_loc_nxt[3:0], lo_loc_nxt[6:4], lo_v_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_frame_loads: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r) else $error("frame record left no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !load_out) else $error("result overwritten while stalled");

endmodule

FILE: hw/rtl/cell_voltage_frame_checker_unit.sv
// top level of the cell voltage frame checker: configuration registers and the three parts
// depends on cvfc_pkg, cvfc_front, cvfc_queue, cvfc_back
// a pec-low beat goes into the record queue, then into the result register behind out_tvalid
// throughput: one byte beat per cycle; a 4-record queue decouples the front from the result
// register, so in_tready drops only when the queue fills behind a stalled out_tready
// reset (synchronous, rst_n low): limits to defaults, stats cleared, crc seeded, queue emptied;
// stored frame bytes are not reset
module cell_voltage_frame_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte[7:0], byte_position[10:8], chip_index[13:11],
                                  // group_index[15:14]
  input  logic [0:0]  in_tuser,   // scan_start[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // min_cell_voltage[15:0], min_chip[18:16], min_cell[22:19],
                                  // max_cell_voltage[38:23], max_chip[41:39],
                                  // max_cell[45:42], pack_total[68:46], under_voltage[69],
                                  // over_voltage[70], pack_over_voltage[71]
  output logic [0:0]  out_tuser,  // pec_ok[0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [22:0] cfg_wdata
);

  cvfc_pkg::cfg_t cfg_r, cfg_nxt;
  cvfc_pkg::rec_t push_rec, head;
  logic           push, pop, q_valid, q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cvfc_pkg::cfg_idx_t'(cfg_addr))
        cvfc_pkg::CFG_UNDER_LIMIT: cfg_nxt.under_limit = cfg_wdata[15:0];
        cvfc_pkg::CFG_OVER_LIMIT:  cfg_nxt.over_limit  = cfg_wdata[15:0];
        cvfc_pkg::CFG_PACK_LIMIT:  cfg_nxt.pack_limit  = cfg_wdata[22:0];
        cvfc_pkg::CFG_EVEN_CELLS:  cfg_nxt.even_cells  = cfg_wdata[3:0];
        cvfc_pkg::CFG_ODD_CELLS:   cfg_nxt.odd_cells   = cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.under_limit <= cvfc_pkg::UNDER_RST;
      cfg_r.over_limit  <= cvfc_pkg::OVER_RST;
      cfg_r.pack_limit  <= cvfc_pkg::PACK_RST;
      cfg_r.even_cells  <= cvfc_pkg::EVEN_RST;
      cfg_r.odd_cells   <= cvfc_pkg::ODD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cvfc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .rx_byte       (in_tdata[7:0]),
    .byte_position (in_tdata[10:8]),
    .chip_index    (in_tdata[13:11]),
    .group_index   (in_tdata[15:14]),
    .scan_start    (in_tuser[0]),
    .q_full        (q_full),
    .push          (push),
    .rec           (push_rec)
  );

  cvfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .q_valid  (q_valid),
    .q_full   (q_full)
  );

  cvfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .q_valid    (q_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser[0])
  );

endmodule
